### hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the tick task scheduler
// Slot record, command/result words, op and result codes, control structs.
// ----------------------------------------------------------------------------
package tts_pkg;

  // sizing
  localparam int TASK_SLOTS  = 8;
  localparam int TIME_BITS   = 16;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int RUNS_MAX    = 255;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  // result kinds
  typedef enum logic [2:0] {
    K_ADDED   = 3'd0,
    K_FULL    = 3'd1,
    K_DELETED = 3'd2,
    K_TICKED  = 3'd3,
    K_RUN     = 3'd4,
    K_IDLE    = 3'd5
  } kind_t;

  // slot update unit operations
  typedef enum logic [1:0] {
    ALU_LOAD,
    ALU_CLEAR,
    ALU_TICK,
    ALU_RUN
  } alu_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_TICK,
    ST_DISP,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  task_handle;
    logic [15:0] start_delay;
    logic [15:0] run_period;
    logic [15:0] repeat_count;
    logic [2:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [2:0] slot_number;
    logic [7:0] run_handle;
    logic       last_result;
  } out_word_t;

  typedef struct packed {
    logic [7:0]           handle;
    logic [TIME_BITS-1:0] delay;
    logic [TIME_BITS-1:0] period;
    logic [7:0]           pending;
    logic [TIME_BITS-1:0] repeats;
  } slot_rec_t;

  // sequencer -> table / update unit
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    alu_op_t           alu_op;
    slot_rec_t         add_rec;
  } tbl_ctl_t;

  // table -> sequencer
  typedef struct packed {
    logic [TASK_SLOTS-1:0] ready;
    logic [TASK_SLOTS-1:0] free;
  } tbl_stat_t;

endpackage

### hw/rtl/tts_slot_alu.sv
// ----------------------------------------------------------------------------
// tts_slot_alu: shared slot update unit
// Computes the new record of one slot for load, clear, tick or run.
// ----------------------------------------------------------------------------
module tts_slot_alu import tts_pkg::*; (
  input  alu_op_t   op,
  input  slot_rec_t cur_rec,
  input  slot_rec_t add_rec,
  output slot_rec_t new_rec
);

  logic [TIME_BITS-1:0] rep_dec;

  // repeat count after one run, floored at zero
  assign rep_dec = (cur_rec.repeats != '0) ? cur_rec.repeats - 1'b1 : cur_rec.repeats;

  always_comb begin
    new_rec = cur_rec;
    unique case (op)
      ALU_LOAD: begin
        new_rec = add_rec;
      end
      ALU_CLEAR: begin
        new_rec = '0;
      end
      ALU_TICK: begin
        // empty slots are left alone
        if (cur_rec.handle != '0) begin
          if (cur_rec.delay == '0) begin
            if (cur_rec.pending != 8'(RUNS_MAX)) begin
              new_rec.pending = cur_rec.pending + 1'b1;
            end
            if (cur_rec.period != '0) begin
              new_rec.delay = cur_rec.period - 1'b1;
            end
          end else begin
            new_rec.delay = cur_rec.delay - 1'b1;
          end
        end
      end
      ALU_RUN: begin
        new_rec.pending = cur_rec.pending - 1'b1;
        new_rec.repeats = rep_dec;
        // one-shot or out of repeats: slot is freed
        if (cur_rec.period == '0 || rep_dec == '0) begin
          new_rec = '0;
        end
      end
    endcase
  end

endmodule

### hw/rtl/tts_slot_table.sv
// ----------------------------------------------------------------------------
// tts_slot_table: task slot storage
// One write port, one read port at the sequencer cursor, ready/free flags.
// ----------------------------------------------------------------------------
module tts_slot_table import tts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tbl_ctl_t  ctl,
  input  slot_rec_t wr_rec,
  output slot_rec_t rd_rec,
  output tbl_stat_t stat
);

  slot_rec_t slots_r [TASK_SLOTS];

  // storage, cleared at reset so every slot starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slots_r[i] <= '0;
      end
    end else if (ctl.wr_en) begin
      slots_r[ctl.wr_slot] <= wr_rec;
    end
  end

  assign rd_rec = slots_r[ctl.rd_slot];

  // per-slot flags
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      stat.free[i]  = (slots_r[i].handle == '0);
      stat.ready[i] = (slots_r[i].handle != '0) && (slots_r[i].pending != '0);
    end
  end

endmodule

### hw/rtl/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl: scheduler sequencer
// Takes a word, walks slots one per cycle unless output-held, loads results.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_data,
  output logic      in_stall,
  input  logic      out_free,
  input  tbl_stat_t stat,
  input  slot_rec_t rd_rec,
  output tbl_ctl_t  ctl,
  output logic      out_load,
  output out_word_t out_word
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  state_t            state_r, state_nxt;
  in_word_t          cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  kind_t             kind_r, kind_nxt;
  logic [2:0]        rslot_r, rslot_nxt;

  logic [SLOT_W-1:0]     first_free;
  logic [TASK_SLOTS-1:0] ready_above;
  logic                  run_last;

  // lowest free slot
  always_comb begin
    first_free = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (stat.free[i]) begin
        first_free = SLOT_W'(i);
      end
    end
  end

  // ready slots past the cursor decide the final run word
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      ready_above[i] = stat.ready[i] && (SLOT_W'(i) > cursor_r);
    end
  end

  assign run_last = (ready_above == '0) || (cnt_r == CNT_W'(MAX_RESULTS - 1));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cursor_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    kind_r  <= kind_nxt;
    rslot_r <= rslot_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    cursor_nxt  = cursor_r;
    cnt_nxt     = cnt_r;
    kind_nxt    = kind_r;
    rslot_nxt   = rslot_r;
    in_stall    = (state_r != ST_IDLE);
    out_load    = 1'b0;
    out_word    = '0;
    ctl.wr_en   = 1'b0;
    ctl.wr_slot = cursor_r;
    ctl.rd_slot = cursor_r;
    ctl.alu_op  = ALU_CLEAR;
    ctl.add_rec.handle  = cmd_r.task_handle;
    ctl.add_rec.delay   = TIME_BITS'(cmd_r.start_delay);
    ctl.add_rec.period  = TIME_BITS'(cmd_r.run_period);
    ctl.add_rec.pending = '0;
    ctl.add_rec.repeats = TIME_BITS'(cmd_r.repeat_count);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data;
          cursor_nxt = '0;
          cnt_nxt    = '0;
          unique case (in_data.operation)
            OP_ADD, OP_DEL: state_nxt = ST_SINGLE;
            OP_TICK:        state_nxt = ST_TICK;
            OP_DISP:        state_nxt = ST_DISP;
          endcase
        end
      end

      ST_SINGLE: begin
        state_nxt = ST_DONE;
        if (cmd_r.operation == OP_ADD) begin
          if (stat.free != '0) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_slot = first_free;
            ctl.alu_op  = ALU_LOAD;
            kind_nxt    = K_ADDED;
            rslot_nxt   = 3'(first_free);
          end else begin
            kind_nxt  = K_FULL;
            rslot_nxt = '0;
          end
        end else begin
          // delete: slots beyond the table are reported but untouched
          if (32'(cmd_r.slot_index) < 32'(TASK_SLOTS)) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_slot = SLOT_W'(cmd_r.slot_index);
            ctl.alu_op  = ALU_CLEAR;
          end
          kind_nxt  = K_DELETED;
          rslot_nxt = cmd_r.slot_index;
        end
      end

      ST_TICK: begin
        ctl.wr_en  = 1'b1;
        ctl.alu_op = ALU_TICK;
        if (cursor_r == LAST_SLOT) begin
          kind_nxt  = K_TICKED;
          rslot_nxt = '0;
          state_nxt = ST_DONE;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
        end
      end

      ST_DISP: begin
        ctl.alu_op = ALU_RUN;
        if (stat.ready[cursor_r]) begin
          // hold on this slot until the output register can take the word
          if (out_free) begin
            ctl.wr_en            = 1'b1;
            out_load             = 1'b1;
            out_word.result_kind = K_RUN;
            out_word.slot_number = 3'(cursor_r);
            out_word.run_handle  = rd_rec.handle;
            out_word.last_result = run_last;
            cnt_nxt              = cnt_r + 1'b1;
            if (run_last || cursor_r == LAST_SLOT) begin
              state_nxt = ST_IDLE;
            end else begin
              cursor_nxt = cursor_r + 1'b1;
            end
          end
        end else if (cursor_r == LAST_SLOT) begin
          // walked the whole table with nothing ready
          kind_nxt  = K_IDLE;
          rslot_nxt = '0;
          state_nxt = ST_DONE;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_word.result_kind = kind_r;
          out_word.slot_number = rslot_r;
          out_word.run_handle  = '0;
          out_word.last_result = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/tick_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// tick_task_scheduler_core: time-triggered cooperative task scheduler
// Input channel (in_valid/in_stall/in_data) takes one command word: add a
// task, delete a slot, tick the timer or dispatch ready tasks. Output channel
// (out_valid/out_stall/out_data) returns result words; the final word of a
// command has last_result set.
// Timing: a command is taken only while the sequencer is idle. Add and delete
// write their slot in a single state, then give their word from the done
// state; the next command can go in once the sequencer is idle again. Tick
// visits every slot once through the shared slot update unit, then gives its
// word from the done state. Dispatch visits the slots in order, one per cycle
// unless a run word waits on the output register, sends one word per ready
// slot (or one idle word) and ends right after the last run word. The table
// has a single slot read/write port. Reset clears the whole slot table at
// once, so all slots start empty. A stalled receiver freezes the output
// register; a sequencer with a word to load then holds, in dispatch on the
// current slot, and the input stays stalled until the word is taken.
// ----------------------------------------------------------------------------
module tick_task_scheduler_core import tts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  tbl_ctl_t  ctl;
  tbl_stat_t stat;
  slot_rec_t rd_rec;
  slot_rec_t wr_rec;
  logic      out_load;
  out_word_t out_word;
  logic      out_free;
  logic      out_valid_r;
  out_word_t out_data_r;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_free (out_free),
    .stat     (stat),
    .rd_rec   (rd_rec),
    .ctl      (ctl),
    .out_load (out_load),
    .out_word (out_word)
  );

  tts_slot_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .wr_rec (wr_rec),
    .rd_rec (rd_rec),
    .stat   (stat)
  );

  tts_slot_alu u_alu (
    .op      (ctl.alu_op),
    .cur_rec (rd_rec),
    .add_rec (ctl.add_rec),
    .new_rec (wr_rec)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
